// ----- hw/rtl/sus_pkg.sv -----
`timescale 1ns / 1ps

package sus_pkg;

    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int OCC_W       = 6;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - VAL_W - OCC_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOTFOUND  = 3'd3,
        ST_FULL      = 3'd4,
        ST_DUMP      = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [VAL_W-1:0]  operand;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/sus_cell.sv -----
`timescale 1ns / 1ps

module sus_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic                             clk,
    input  sus_pkg::cell_ctrl_t              ctrl,
    input  logic [CNT_W-1:0]                 count,
    input  logic signed [sus_pkg::VAL_W-1:0] left_val,
    input  logic                             left_lt,
    input  logic signed [sus_pkg::VAL_W-1:0] right_val,
    input  logic                             right_occ,
    input  logic signed [sus_pkg::VAL_W-1:0] head_val,
    output logic signed [sus_pkg::VAL_W-1:0] val,
    output logic                             occ,
    output logic                             lt,
    output logic                             eq
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic signed [sus_pkg::VAL_W-1:0] val_reg;
    logic signed [sus_pkg::VAL_W-1:0] val_next;

    assign occ = IDX_C < count;
    assign lt  = occ && (val_reg < ctrl.operand);
    assign eq  = occ && (val_reg == ctrl.operand);
    assign val = val_reg;

    always_comb
    begin
        case (ctrl.op)
            sus_pkg::CELL_INSERT:
            begin
                if (lt)
                    val_next = val_reg;
                else if (left_lt)
                    val_next = ctrl.operand;
                else
                    val_next = left_val;
            end
            sus_pkg::CELL_DELETE:
            begin
                val_next = lt ? val_reg : right_val;
            end
            sus_pkg::CELL_ROTATE:
            begin
                val_next = right_occ ? right_val : head_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ----- hw/rtl/sorted_unique_set_top.sv -----
`timescale 1ns / 1ps
// sorted set of signed 32-bit values, ascending, no duplicates, up to CAPACITY
// s_axis word: op (insert, delete, dump) and value
// m_axis word: status, element, occupancy; tlast marks the final word of an item
// storage is a row of cells, each holding one value and comparing it with the
// incoming value in parallel, then shifting left or right by one in the same edge
// insert and delete: each accepted word gives one output word, which sits in the output register
// the cycle after acceptance
// dump: the row rotates one cell per cycle through cell 0 while the receiver
// takes words, so a dump of n values gives n words after a start step; an empty
// set gives one word the cycle after acceptance
// no new word is taken while a dump runs
// when the receiver stalls, the output register holds and input is not taken
// reset clears the count, the dump state and the output valid; cell contents
// are kept but ignored, so the set starts empty with no clearing pass
module sorted_unique_set_top #(
    parameter int CAPACITY = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // op[1:0], value[33:2], zero pad
    input  logic [sus_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status[2:0], element[34:3], occupancy[40:35], zero pad
    output logic [sus_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    logic signed [sus_pkg::VAL_W-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]              cell_occ;
    logic [CAPACITY-1:0]              cell_lt;
    logic [CAPACITY-1:0]              cell_eq;
    sus_pkg::cell_ctrl_t              ctrl;

    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [CNT_W-1:0]                 rem_reg, rem_next;
    logic                             dump_reg, dump_next;
    logic                             ovalid_reg, ovalid_next;
    sus_pkg::status_t                 status_reg, status_next;
    logic signed [sus_pkg::VAL_W-1:0] elem_reg, elem_next;
    logic [CNT_W-1:0]                 occ_reg, occ_next;
    logic                             last_reg, last_next;

    sus_pkg::op_t                     op_in;
    logic signed [sus_pkg::VAL_W-1:0] val_in;
    logic                             take;
    logic                             in_acc;
    logic                             found;
    logic                             full;

    assign op_in  = sus_pkg::op_t'(s_tdata[sus_pkg::OP_W-1:0]);
    assign val_in = s_tdata[sus_pkg::OP_W +: sus_pkg::VAL_W];
    assign take   = !ovalid_reg || m_tready;
    assign s_tready = take && !dump_reg;
    assign in_acc = s_tvalid && s_tready;
    assign found  = |cell_eq;
    assign full   = count_reg >= CAP_C;

    always_comb
    begin
        ctrl.operand = val_in;
        ctrl.op      = sus_pkg::CELL_HOLD;
        if (in_acc && op_in == sus_pkg::OP_INSERT && !found && !full)
            ctrl.op = sus_pkg::CELL_INSERT;
        else if (in_acc && op_in == sus_pkg::OP_DELETE && found)
            ctrl.op = sus_pkg::CELL_DELETE;
        else if (dump_reg && take)
            ctrl.op = sus_pkg::CELL_ROTATE;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [sus_pkg::VAL_W-1:0] lv;
        logic                             llt;
        logic signed [sus_pkg::VAL_W-1:0] rv;
        logic                             rocc;

        if (i == 0)
        begin : g_first
            assign lv  = val_in;
            assign llt = 1'b1;
        end
        else
        begin : g_mid
            assign lv  = cell_val[i-1];
            assign llt = cell_lt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rv   = cell_val[i];
            assign rocc = 1'b0;
        end
        else
        begin : g_body
            assign rv   = cell_val[i+1];
            assign rocc = cell_occ[i+1];
        end

        sus_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .left_val  (lv),
            .left_lt   (llt),
            .right_val (rv),
            .right_occ (rocc),
            .head_val  (cell_val[0]),
            .val       (cell_val[i]),
            .occ       (cell_occ[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        case (ctrl.op)
            sus_pkg::CELL_INSERT: count_next = count_reg + ONE_C;
            sus_pkg::CELL_DELETE: count_next = count_reg - ONE_C;
            default:              count_next = count_reg;
        endcase
    end

    always_comb
    begin
        rem_next    = rem_reg;
        dump_next   = dump_reg;
        ovalid_next = ovalid_reg;
        status_next = status_reg;
        elem_next   = elem_reg;
        occ_next    = occ_reg;
        last_next   = last_reg;
        if (in_acc)
        begin
            elem_next = val_in;
            occ_next  = count_next;
            last_next = 1'b1;
            case (op_in)
                sus_pkg::OP_INSERT:
                begin
                    ovalid_next = 1'b1;
                    if (found)
                        status_next = sus_pkg::ST_DUPLICATE;
                    else if (full)
                        status_next = sus_pkg::ST_FULL;
                    else
                        status_next = sus_pkg::ST_INSERTED;
                end
                sus_pkg::OP_DELETE:
                begin
                    ovalid_next = 1'b1;
                    status_next = found ? sus_pkg::ST_DELETED : sus_pkg::ST_NOTFOUND;
                end
                sus_pkg::OP_DUMP:
                begin
                    if (count_reg == '0)
                    begin
                        ovalid_next = 1'b1;
                        status_next = sus_pkg::ST_EMPTY;
                        elem_next   = '0;
                    end
                    else
                    begin
                        ovalid_next = 1'b0;
                        dump_next   = 1'b1;
                        rem_next    = count_reg;
                    end
                end
                default:
                begin
                    ovalid_next = 1'b0;
                end
            endcase
        end
        else if (dump_reg && take)
        begin
            ovalid_next = 1'b1;
            status_next = sus_pkg::ST_DUMP;
            elem_next   = cell_val[0];
            occ_next    = count_reg;
            last_next   = rem_reg == ONE_C;
            rem_next    = rem_reg - ONE_C;
            dump_next   = rem_reg != ONE_C;
        end
        else if (take)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rem_reg    <= '0;
            dump_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rem_reg    <= rem_next;
            dump_reg   <= dump_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        elem_reg   <= elem_next;
        occ_reg    <= occ_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{sus_pkg::OUT_PAD_W{1'b0}},
                       sus_pkg::OCC_W'(occ_reg),
                       elem_reg,
                       status_reg};

endmodule
